// ----- src/fns_pkg.sv -----
// Shared types and constants for the filtered noise synthesizer.
// No dependencies; imported by every module of the block.
package fns_pkg;

    localparam logic [31:0] LCG_MUL     = 32'd1103515245;
    localparam logic [31:0] LCG_INC     = 32'd12345;
    localparam logic [23:0] TOTAL_RESET = 24'd1323000;
    localparam logic [31:0] SEED_RESET  = 32'd14;
    localparam logic [18:0] TRI_MID     = 19'h40000;
    localparam logic [23:0] ENV_CAP     = 24'h020000;
    localparam int          QDEPTH_DEF  = 2;

    // Register index, taken from paddr[2]
    localparam logic REG_TOTAL = 1'b0;
    localparam logic REG_SEED  = 1'b1;

    typedef struct packed {
        logic [23:0] total_frames;
        logic [31:0] seed_start;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic restart;
    } t_cmd;

    typedef struct packed {
        logic pop;
        logic in_out_state;
    } t_back_sts;

endpackage

// ----- src/filtered_noise_synth_core.sv -----
// Top level of the filtered noise synthesizer.
// Depends on fns_pkg, fns_cfg, fns_front and fns_back.
//
// Usage:
//   Request channel (i_in_valid / o_in_stall, i_restart): each accepted item
//   asks for one audio sample; i_restart = 1 starts a new rendition first.
//   Result channel (o_out_valid / i_out_stall, o_sample, o_last_sample):
//   one signed 16-bit PCM sample per request, o_last_sample marks the final
//   sample of the rendition, after which the generator restarts by itself.
//   Registers (APB, pready always high): 0x0 total_frames, 0x4 seed_start.
//   Write them only while no request is in flight.
// Timing:
//   The back end finishes one item before it takes the next: the sample
//   sequencer walks the generator multiply, three filter updates and two
//   gain multiplies one per cycle. A request queue (QDEPTH entries) accepts
//   items while the back end works.
// Reset and stall:
//   Synchronous active-low reset loads the register defaults, clears the
//   filters, counter and queue, and drops o_out_valid. While the receiver
//   stalls, the sample is held and the sequencer waits at its final step;
//   requests keep queuing until the queue is full.
module filtered_noise_synth_core
    import fns_pkg::*;
#(
    parameter int QDEPTH = QDEPTH_DEF
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_restart,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_sample,
    output logic               o_last_sample,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg      w_cfg;
    t_cmd      w_cmd;
    t_back_sts w_sts;

    fns_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    fns_front #(.QDEPTH(QDEPTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_restart  (i_restart),
        .i_pop      (w_sts.pop),
        .o_cmd      (w_cmd)
    );

    fns_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_sample      (o_sample),
        .o_last_sample (o_last_sample)
    );

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.pop |-> w_cmd.valid)
        else $error("back end popped an empty queue");

    a_result_from_final_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_sts.in_out_state))
        else $error("result raised outside the final step");

endmodule

// ----- src/fns_cfg.sv -----
// APB-style register file: total_frames and seed_start.
// Depends on fns_pkg.
module fns_cfg
    import fns_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [23:0] r_total;
    logic [31:0] r_seed;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= TOTAL_RESET;
            r_seed  <= SEED_RESET;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_TOTAL: r_total <= pwdata[23:0];
                REG_SEED:  r_seed  <= pwdata;
                default:   r_seed  <= r_seed;
            endcase
        end
    end

    // paddr[1:0] address bytes within a word and are ignored
    always_comb begin
        unique case (paddr[2])
            REG_TOTAL: prdata = {8'd0, r_total};
            REG_SEED:  prdata = r_seed;
            default:   prdata = 32'd0;
        endcase
    end

    assign o_cfg.total_frames = r_total;
    assign o_cfg.seed_start   = r_seed;

endmodule

// ----- src/fns_front.sv -----
// Front end: accepts request items and queues their restart flag.
// Depends on fns_pkg; feeds fns_back through a short queue.
module fns_front
    import fns_pkg::*;
#(
    parameter int QDEPTH = QDEPTH_DEF
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  logic i_restart,
    input  logic i_pop,
    output t_cmd o_cmd
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    logic          r_mem [QDEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_push, w_pop;

    assign o_in_stall = (r_count == CW'(QDEPTH));
    assign w_push     = i_in_valid & ~o_in_stall;
    assign w_pop      = i_pop & (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_restart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_cmd.valid   = (r_count != '0);
    assign o_cmd.restart = r_mem[r_rd_ptr];

endmodule

// ----- src/fns_back.sv -----
// Back end: noise generator, filter chain, triangle and envelope gain,
// output register. Depends on fns_pkg; takes items from fns_front.
module fns_back
    import fns_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_cmd               i_cmd,
    output t_back_sts          o_sts,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_sample,
    output logic               o_last_sample
);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_LCG  = 9'b000000010,
        ST_P1   = 9'b000000100,
        ST_P2   = 9'b000001000,
        ST_P3   = 9'b000010000,
        ST_MUL1 = 9'b000100000,
        ST_SUB  = 9'b001000000,
        ST_ENV  = 9'b010000000,
        ST_OUT  = 9'b100000000
    } t_state;

    t_state r_state;

    logic [31:0]        r_noise, r_prod;
    logic [15:0]        r_p1, r_p2, r_p3;
    logic [23:0]        r_idx;
    logic [18:0]        r_tri;
    logic [17:0]        r_gain;
    logic               r_last;
    logic [16:0]        r_v;
    logic [17:0]        r_va;
    logic signed [36:0] r_m1, r_m2;
    logic               r_out_valid;
    logic [15:0]        r_sample;
    logic               r_out_last;

    logic [31:0]        w_noise;
    logic [15:0]        w_x;
    logic signed [16:0] w_d1, w_d2, w_d3, w_v;
    logic signed [16:0] w_s1, w_s2, w_s3;
    logic [16:0]        w_att;
    logic [24:0]        w_rem_full;
    logic [23:0]        w_rem, w_gmin;
    logic [18:0]        w_tri;
    logic [17:0]        w_gain;
    logic               w_last;
    logic               w_out_free;
    logic               w_load;

    assign w_out_free = ~r_out_valid | ~i_out_stall;
    assign w_load     = (r_state == ST_OUT) & w_out_free;

    // Noise: top half of the new generator value, recentered to signed
    assign w_noise = r_prod + LCG_INC;
    assign w_x     = {~w_noise[31], w_noise[30:16]};

    assign w_d1 = $signed({w_x[15], w_x}) - $signed({r_p1[15], r_p1});
    assign w_d2 = $signed({r_p1[15], r_p1}) - $signed({r_p2[15], r_p2});
    assign w_d3 = $signed({r_p2[15], r_p2}) - $signed({r_p3[15], r_p3});
    assign w_v  = w_d3;
    assign w_s1 = w_d1 >>> 7;
    assign w_s2 = w_d2 >>> 8;
    assign w_s3 = w_d3 >>> 11;

    assign w_att = r_m1[36:20];

    // Triangle magnitude |(i mod 2^19) - 2^18|
    assign w_tri = r_idx[18] ? {1'b0, r_idx[17:0]} : TRI_MID - {1'b0, r_idx[17:0]};

    // Envelope: min(i, max(total - i, 0)), capped
    assign w_rem_full = {1'b0, i_cfg.total_frames} - {1'b0, r_idx};
    assign w_rem      = w_rem_full[24] ? 24'd0 : w_rem_full[23:0];
    assign w_gmin     = (r_idx < w_rem) ? r_idx : w_rem;
    assign w_gain     = (w_gmin > ENV_CAP) ? ENV_CAP[17:0] : w_gmin[17:0];
    assign w_last     = ({1'b0, r_idx} + 25'd1) >= {1'b0, i_cfg.total_frames};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_noise     <= SEED_RESET;
            r_p1        <= '0;
            r_p2        <= '0;
            r_p3        <= '0;
            r_idx       <= '0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd.valid) begin
                        if (i_cmd.restart) begin
                            r_noise <= i_cfg.seed_start;
                            r_p1    <= '0;
                            r_p2    <= '0;
                            r_p3    <= '0;
                            r_idx   <= '0;
                        end
                        r_state <= ST_LCG;
                    end
                end
                ST_LCG: begin
                    r_prod  <= r_noise * LCG_MUL;
                    r_state <= ST_P1;
                end
                ST_P1: begin
                    r_noise <= w_noise;
                    r_p1    <= r_p1 + w_s1[15:0];
                    r_state <= ST_P2;
                end
                ST_P2: begin
                    r_p2    <= r_p2 + w_s2[15:0];
                    r_tri   <= w_tri;
                    r_gain  <= w_gain;
                    r_last  <= w_last;
                    r_state <= ST_P3;
                end
                ST_P3: begin
                    r_p3    <= r_p3 + w_s3[15:0];
                    r_state <= ST_MUL1;
                end
                ST_MUL1: begin
                    r_v     <= w_v;
                    r_m1    <= w_v * $signed({1'b0, r_tri});
                    r_state <= ST_SUB;
                end
                ST_SUB: begin
                    r_va    <= {r_v[16], r_v} - {w_att[16], w_att};
                    r_state <= ST_ENV;
                end
                ST_ENV: begin
                    r_m2    <= $signed(r_va) * $signed({1'b0, r_gain});
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    // hold here until the output register frees up
                    if (w_out_free) begin
                        r_sample    <= {r_m2[29:17], 3'b000};
                        r_out_last  <= r_last;
                        if (r_last) begin
                            r_noise <= i_cfg.seed_start;
                            r_p1    <= '0;
                            r_p2    <= '0;
                            r_p3    <= '0;
                            r_idx   <= '0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_sts.pop          = (r_state == ST_IDLE) & i_cmd.valid;
    assign o_sts.in_out_state = (r_state == ST_OUT);

    assign o_out_valid   = r_out_valid;
    assign o_sample      = r_sample;
    assign o_last_sample = r_out_last;

endmodule

// ----- sim/filtered_noise_synth_core_tb.sv -----
// Self-checking testbench for filtered_noise_synth_core: random request and result traffic,
// register writes between phases, every sample compared with an in-bench synthesizer model.
// Depends on fns_pkg and the block's RTL only.
module filtered_noise_synth_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fns_pkg::*;

    localparam int          CYCLE_LIMIT = 300000;
    localparam int          SHOW_MAX    = 20;
    localparam logic [2:0]  ADDR_TOTAL  = {REG_TOTAL, 2'b00};
    localparam logic [2:0]  ADDR_SEED   = {REG_SEED, 2'b00};

    typedef struct {
        logic [15:0] smp;
        logic        last;
    } sample_exp_t;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic               i_restart     = 1'b0;
    logic               i_out_stall   = 1'b0;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [2:0]         paddr         = '0;
    logic [31:0]        pwdata        = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic signed [15:0] o_sample;
    logic               o_last_sample;
    logic [31:0]        prdata;
    logic               pready;

    filtered_noise_synth_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_restart     (i_restart),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_sample      (o_sample),
        .o_last_sample (o_last_sample),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Synthesizer model state and registers
    logic [23:0] m_total;
    logic [31:0] m_seed;
    logic [31:0] m_lcg;
    logic [23:0] m_index;
    int          m_p1, m_p2, m_p3;

    bit          pending_reqs[$];
    sample_exp_t exp_samples[$];

    int  err_cnt      = 0;
    int  cycle_cnt    = 0;
    int  checked_cnt  = 0;
    int  last_cnt     = 0;
    int  restart_cnt  = 0;
    int  src_gap      = 0;
    int  snk_gap      = 0;
    bit  calm         = 1'b0;
    logic in_fire     = 1'b0;

    function automatic void rendition_start();
        m_lcg   = m_seed;
        m_p1    = 0;
        m_p2    = 0;
        m_p3    = 0;
        m_index = '0;
    endfunction

    function automatic sample_exp_t synth_sample(input logic restart);
        sample_exp_t r;
        longint      x, v, ph, tri_w, g, rem, idx, scaled, wide;
        logic        is_last;
        if (restart) rendition_start();
        m_lcg = m_lcg * LCG_MUL + LCG_INC;
        x = longint'({48'b0, m_lcg[31:16]}) - 32768;
        m_p1 = m_p1 + int'((x - m_p1) >>> 7);
        m_p2 = m_p2 + int'((longint'(m_p1) - m_p2) >>> 8);
        m_p3 = m_p3 + int'((longint'(m_p2) - m_p3) >>> 11);
        v = longint'(m_p2) - m_p3;
        // triangle attenuation over the low 19 index bits
        idx   = longint'({40'b0, m_index});
        ph    = longint'({45'b0, m_index[18:0]}) - longint'(TRI_MID);
        tri_w = (ph < 0) ? -ph : ph;
        v     = v - ((v * tri_w) >>> 20);
        // fade envelope, zero once the index runs past the length
        rem = longint'({40'b0, m_total}) - idx;
        if (rem < 0) rem = 0;
        g = (idx < rem) ? idx : rem;
        if (g > longint'(ENV_CAP)) g = longint'(ENV_CAP);
        scaled = (v * g) >>> 17;
        wide   = scaled << 3;
        r.smp  = wide[15:0];
        is_last = ({1'b0, m_index} + 25'd1) >= {1'b0, m_total};
        r.last = is_last;
        if (is_last) rendition_start();
        else m_index = m_index + 24'd1;
        return r;
    endfunction

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d samples still expected", $time, exp_samples.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Request driver: hold a stalled item, otherwise idle in bursts or send the next one
    always @(negedge i_clk) begin : req_drive
        logic nv, nr;
        nv = 1'b0;
        nr = i_restart;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_restart  <= 1'b0;
        end else if (!(i_in_valid && !in_fire)) begin
            if (src_gap > 0) begin
                src_gap--;
            end else if (pending_reqs.size() > 0) begin
                if (!calm && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(0, 3);
                end else begin
                    nv = 1'b1;
                    nr = pending_reqs.pop_front();
                end
            end
            i_in_valid <= nv;
            i_restart  <= nr;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap--;
            i_out_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            snk_gap = $urandom_range(0, 3);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Result check first, then predict the item accepted at this edge
    always @(posedge i_clk) begin : sample_mon
        sample_exp_t e;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (exp_samples.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= SHOW_MAX)
                        $display("%0t: unexpected sample: expected none, got %0d last %0b",
                                 $time, o_sample, o_last_sample);
                end else begin
                    e = exp_samples.pop_front();
                    checked_cnt++;
                    if (e.last) last_cnt++;
                    if (o_sample !== e.smp || o_last_sample !== e.last) begin
                        err_cnt++;
                        if (err_cnt <= SHOW_MAX)
                            $display("%0t: sample mismatch: expected %0d last %0b, got %0d last %0b",
                                     $time, $signed(e.smp), e.last, o_sample, o_last_sample);
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                if (i_restart) restart_cnt++;
                exp_samples.push_back(synth_sample(i_restart));
            end
            in_fire <= i_in_valid && !o_in_stall;
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
        logic [31:0] want;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (addr[2] == REG_TOTAL) m_total = val[23:0];
        else m_seed = val;
        // read it back
        want = (addr[2] == REG_TOTAL) ? {8'b0, m_total} : m_seed;
        @(negedge i_clk);
        psel   = 1'b1;
        pwrite = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (prdata !== want) begin
            err_cnt++;
            $display("%0t: register 0x%0h readback: expected 0x%08h, got 0x%08h",
                     $time, addr, want, prdata);
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        @(posedge i_clk);
    endtask

    // Wait until every request has been answered, then let the pipeline go quiet
    task automatic settle();
        while (pending_reqs.size() != 0 || i_in_valid || exp_samples.size() != 0)
            @(negedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic send(input bit restart);
        pending_reqs.push_back(restart);
    endtask

    initial begin : stimulus
        logic [23:0] tot;
        logic [31:0] sd;
        bit          noisy;
        m_total = TOTAL_RESET;
        m_seed  = SEED_RESET;
        rendition_start();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        // reset defaults, then a restart in the middle
        send(0); send(0); send(0); send(1); send(0); send(0);
        // zero length: every sample last, gain zero
        settle();
        reg_write(ADDR_TOTAL, 32'd0);
        reg_write(ADDR_SEED, 32'd0);
        send(0); send(1);
        settle();
        reg_write(ADDR_TOTAL, 32'd1);
        reg_write(ADDR_SEED, 32'hFFFF_FFFF);
        send(0); send(0);
        // short rendition, wrap past the end once
        settle();
        reg_write(ADDR_TOTAL, 32'd4);
        reg_write(ADDR_SEED, {8'b0, 24'(SEED_RESET)});
        repeat (6) send(0);
        // new seed mid-run only shows after the restart
        settle();
        reg_write(ADDR_TOTAL, 32'd20);
        send(1); send(0); send(0);
        settle();
        reg_write(ADDR_SEED, 32'h1234_5678);
        send(0); send(0); send(1); send(0);
        // length dropped below the current index
        settle();
        reg_write(ADDR_TOTAL, 32'd1);
        send(0);
        settle();
        reg_write(ADDR_TOTAL, 32'h00FF_FFFF);
        send(0);

        for (int ph = 0; ph < 16; ph++) begin
            settle();
            if (ph >= 14) calm = 1'b1;
            case ($urandom_range(0, 9))
                0:       tot = 24'd0;
                1:       tot = 24'hFF_FFFF;
                2:       tot = 24'($urandom());
                3:       tot = 24'd1;
                default: tot = 24'($urandom_range(2, 200));
            endcase
            reg_write(ADDR_TOTAL, {8'b0, tot});
            if (ph == 0 || $urandom_range(0, 9) < 7) begin
                case ($urandom_range(0, 5))
                    0:       sd = 32'd0;
                    1:       sd = 32'hFFFF_FFFF;
                    default: sd = $urandom();
                endcase
                reg_write(ADDR_SEED, sd);
            end
            noisy = (ph % 4 == 3);
            if (!noisy && $urandom_range(0, 1)) send(1);
            repeat (125) begin
                if (noisy) send(1'($urandom_range(0, 1)));
                else send($urandom_range(0, 99) == 0);
            end
        end

        settle();
        $display("Checked %0d samples (%0d rendition ends, %0d restart requests)",
                 checked_cnt, last_cnt, restart_cnt);
        $display("over directed edge cases and 16 random register settings with idle and stall");
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- filtered_noise_synth_core.f -----
src/fns_pkg.sv
src/fns_cfg.sv
src/fns_front.sv
src/fns_back.sv
src/filtered_noise_synth_core.sv
sim/filtered_noise_synth_core_tb.sv
